FILE: rtl/core/lab_pkg.sv
// Shared constants and vector types of the look-at basis block.
package lab_pkg;

    localparam int CW  = 32;            // coordinate width, signed Q16.16
    localparam int CF  = 16;            // coordinate fraction bits
    localparam int AFB = 14;            // axis fraction bits
    localparam int AW  = AFB + 2;       // axis component width
    // Width of a vector entering a normalizer: holds a coordinate difference
    // and a cross product of two axes.
    localparam int VW  = CW + 2;
    localparam int MW  = VW - 1;        // magnitude width
    localparam int NB  = 31;            // significant bits after scaling
    localparam int LW  = $clog2(MW + 1);
    localparam int SQW = 2 * NB + 2;    // sum of squares width
    localparam int SQN = NB + 1;        // square root iterations
    localparam int DW  = NB + AFB + 1;  // dividend width
    localparam int QB  = AFB + 1;       // quotient bits
    localparam int NL  = NB + AFB + 9;  // normalizer latency in cycles

    localparam logic [2*CF+1:0] NEAR_LIMIT = (2*CF+2)'(429497);
    localparam int LOOK_NUM = 1000;
    localparam int LOOK_LIM = 999;
    localparam logic [AW-1:0] AXIS_ONE = AW'(1) << AFB;

    typedef logic [2:0][VW-1:0] t_vec;
    typedef logic [2:0][AW-1:0] t_axis;

endpackage

FILE: rtl/core/lab_norm.sv
// Pipelined normalizer of a signed three-component vector to unit length.
module lab_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  lab_pkg::t_vec  i_vec,
    output lab_pkg::t_axis o_axis
);
    import lab_pkg::*;

    logic [2:0][MW-1:0]    r_p1_mag;
    logic [2:0]            r_p1_sg;
    logic [2:0][MW-1:0]    r_p2_mag;
    logic [2:0]            r_p2_sg;
    logic [LW-1:0]         r_p2_len;
    logic [2:0][NB-1:0]    r_p3_m;
    logic [2:0]            r_p3_sg;
    logic                  r_p3_z;
    logic [2:0][2*NB-1:0]  r_p4_sq;
    logic [2:0][NB-1:0]    r_p4_m;
    logic [2:0]            r_p4_sg;
    logic                  r_p4_z;

    logic [SQW-1:0]        r_sq_x  [0:SQN];
    logic [SQW-1:0]        r_sq_r  [0:SQN];
    logic [2:0][NB-1:0]    r_sq_m  [0:SQN];
    logic [2:0]            r_sq_sg [0:SQN];
    logic                  r_sq_z  [0:SQN];

    logic [2:0][DW-1:0]    r_dv_rem [0:QB];
    logic [2:0][QB-1:0]    r_dv_q   [0:QB];
    logic [NB:0]           r_dv_n   [0:QB];
    logic [2:0]            r_dv_sg  [0:QB];
    logic                  r_dv_z   [0:QB];

    t_axis                 r_out;

    logic [2:0][MW-1:0]    n_mag;
    logic [LW-1:0]         n_len;
    logic [2:0][NB-1:0]    n_m;
    logic [MW+NB-1:0]      w_wide [0:2];
    logic [VW-1:0]         w_neg  [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_neg[c] = -i_vec[c];
            n_mag[c] = i_vec[c][VW-1] ? w_neg[c][MW-1:0] : i_vec[c][MW-1:0];
        end
    end

    // Bit length of the largest magnitude.
    always_comb begin
        n_len = '0;
        for (int i = 0; i < MW; i++) begin
            if ((r_p1_mag[0][i] | r_p1_mag[1][i] | r_p1_mag[2][i]) == 1'b1) begin
                n_len = LW'(i + 1);
            end
        end
    end

    // Scale so that the largest magnitude has exactly NB significant bits.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_wide[c] = {r_p2_mag[c], {NB{1'b0}}} >> r_p2_len;
            n_m[c] = w_wide[c][NB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_mag <= n_mag;
            for (int c = 0; c < 3; c++) begin
                r_p1_sg[c] <= i_vec[c][VW-1];
            end
            r_p2_mag <= r_p1_mag;
            r_p2_sg  <= r_p1_sg;
            r_p2_len <= n_len;
            r_p3_m   <= n_m;
            r_p3_sg  <= r_p2_sg;
            r_p3_z   <= (r_p2_len == '0);
            for (int c = 0; c < 3; c++) begin
                r_p4_sq[c] <= (2*NB)'(r_p3_m[c]) * (2*NB)'(r_p3_m[c]);
            end
            r_p4_m  <= r_p3_m;
            r_p4_sg <= r_p3_sg;
            r_p4_z  <= r_p3_z;
            r_sq_x[0]  <= SQW'(r_p4_sq[0]) + SQW'(r_p4_sq[1]) + SQW'(r_p4_sq[2]);
            r_sq_r[0]  <= '0;
            r_sq_m[0]  <= r_p4_m;
            r_sq_sg[0] <= r_p4_sg;
            r_sq_z[0]  <= r_p4_z;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar g = 0; g < SQN; g++) begin : g_sq
        localparam int E = SQN - 1 - g;
        logic [SQW-1:0] w_bit;
        logic [SQW-1:0] w_try;
        assign w_bit = SQW'(1) << (2 * E);
        assign w_try = r_sq_r[g] + w_bit;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sq_x[g] >= w_try) begin
                    r_sq_x[g+1] <= r_sq_x[g] - w_try;
                    r_sq_r[g+1] <= (r_sq_r[g] >> 1) + w_bit;
                end else begin
                    r_sq_x[g+1] <= r_sq_x[g];
                    r_sq_r[g+1] <= r_sq_r[g] >> 1;
                end
                r_sq_m[g+1]  <= r_sq_m[g];
                r_sq_sg[g+1] <= r_sq_sg[g];
                r_sq_z[g+1]  <= r_sq_z[g];
            end
        end
    end

    // Dividend with half the norm added gives rounding half away from zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_dv_rem[0][c] <= DW'({r_sq_m[SQN][c], {AFB{1'b0}}})
                                + DW'(r_sq_r[SQN][NB:1]);
            end
            r_dv_q[0]  <= '0;
            r_dv_n[0]  <= r_sq_r[SQN][NB:0];
            r_dv_sg[0] <= r_sq_sg[SQN];
            r_dv_z[0]  <= r_sq_z[SQN];
        end
    end

    // Restoring division, one quotient bit per stage for all components.
    for (genvar k = 0; k < QB; k++) begin : g_dv
        localparam int B = QB - 1 - k;
        logic [DW-1:0] w_dsh;
        assign w_dsh = DW'(r_dv_n[k]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_dv_rem[k][c] >= w_dsh) begin
                        r_dv_rem[k+1][c]  <= r_dv_rem[k][c] - w_dsh;
                        r_dv_q[k+1][c]    <= r_dv_q[k][c] | (QB'(1) << B);
                    end else begin
                        r_dv_rem[k+1][c]  <= r_dv_rem[k][c];
                        r_dv_q[k+1][c]    <= r_dv_q[k][c];
                    end
                end
                r_dv_n[k+1]  <= r_dv_n[k];
                r_dv_sg[k+1] <= r_dv_sg[k];
                r_dv_z[k+1]  <= r_dv_z[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_dv_z[QB]) begin
                    r_out[c] <= '0;
                end else if (r_dv_sg[QB][c]) begin
                    r_out[c] <= -AW'(r_dv_q[QB][c]);
                end else begin
                    r_out[c] <= AW'(r_dv_q[QB][c]);
                end
            end
        end
    end

    assign o_axis = r_out;

endmodule

FILE: rtl/core/look_at_basis_matrix.sv
// Top level of the look-at basis block: facing frame of an object, Z up.
//
// Input channel (s_axis): one transaction carries the object and target
// positions. Output channel (m_axis): one transaction carries the forward,
// side and third axes in signed Q2.14 and the translation.
// Each input transaction yields exactly one output transaction, in order.
// An accepted item passes through three normalizers of 54 stages each
// (square root one bit per stage, division one quotient bit per stage) and
// through the stages of difference, axis selection, cross product and
// output register.
// One item is accepted in every cycle while the output is taken or empty.
// Reset clears all valid bits; no item is in flight afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready drops; nothing is lost or repeated.
// Coincident positions give the identity basis; a forward axis close to
// vertical builds the side axis from the X axis instead of world up.
module look_at_basis_matrix (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // obj_x, obj_y, obj_z, tgt_x, tgt_y, tgt_z
    input  logic [6*lab_pkg::CW-1:0]                 i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // fwd_x, fwd_y, fwd_z, side_x, side_y, side_z, up_x, up_y, up_z,
    // pos_x, pos_y, pos_z
    output logic [9*lab_pkg::AW+3*lab_pkg::CW-1:0]   o_m_axis_tdata
);
    import lab_pkg::*;

    typedef struct packed {
        logic               near;
        logic [2:0][CW-1:0] obj;
        t_axis              f;
        t_axis              s;
    } t_carry;

    logic               w_en;
    logic [2:0][CW-1:0] w_obj;
    logic [2:0][CW-1:0] w_tgt;
    t_vec               n_d;
    t_axis              w_f;
    t_axis              w_s;
    t_axis              w_u;

    logic               r1_v [0:NL];
    t_carry             r1_c [0:NL];
    logic               r2_v [0:NL];
    t_carry             r2_c [0:NL];
    logic               r3_v [0:NL];
    t_carry             r3_c [0:NL];
    logic               r_x1_v;
    t_carry             r_x1_c;
    logic               r_out_v;

    t_vec               r_a_d;
    logic [2:0][CF-1:0] r_b_lo;
    logic               r_b_small;
    logic [2:0][2*CF-1:0] r_c_sq;
    logic               r_c_small;
    t_vec               r_t;
    t_vec               r_u;
    logic signed [2*AW-1:0] r_x1_p [0:5];

    t_axis              r_out_fwd;
    t_axis              r_out_side;
    t_axis              r_out_up;
    logic [2:0][CW-1:0] r_out_pos;

    logic [2:0][VW-1:0] n_mg;
    logic [2:0][CF-1:0] n_lo;
    logic               n_small;
    logic [2*CF+1:0]    n_sum;
    logic [AW-1:0]      n_fzmag;
    logic               n_vert;
    t_vec               n_t;
    t_vec               n_u;
    t_carry             n_c0;
    t_carry             n_c3;
    t_carry             n_c2;
    t_carry             n_x1;

    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_obj           = i_s_axis_tdata[3*CW-1:0];
    assign w_tgt           = i_s_axis_tdata[6*CW-1:3*CW];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_d[c] = VW'($signed(w_tgt[c])) - VW'($signed(w_obj[c]));
        end
        n_c0.near = 1'b0;
        n_c0.obj  = w_obj;
        n_c0.f    = '0;
        n_c0.s    = '0;
    end

    // Near test: every difference below one unit and squared length small.
    always_comb begin
        n_small = 1'b1;
        for (int c = 0; c < 3; c++) begin
            n_mg[c] = r_a_d[c][VW-1] ? -r_a_d[c] : r_a_d[c];
            if (n_mg[c][MW-1:CF] != '0) begin
                n_small = 1'b0;
            end
            n_lo[c] = n_mg[c][CF-1:0];
        end
        n_sum = (2*CF+2)'(r_c_sq[0]) + (2*CF+2)'(r_c_sq[1]) + (2*CF+2)'(r_c_sq[2]);
    end

    // Carry words that pick up a result on their way down the pipeline.
    always_comb begin
        n_c3      = r1_c[2];
        n_c3.near = r_c_small && (n_sum < NEAR_LIMIT);
        n_c2      = r1_c[NL];
        n_c2.f    = w_f;
        n_x1      = r2_c[NL];
        n_x1.s    = w_s;
    end

    // Side axis source: world up, or the X axis when forward is near vertical.
    always_comb begin
        n_fzmag = w_f[2][AW-1] ? -w_f[2] : w_f[2];
        n_vert  = (64'(n_fzmag) * 64'(LOOK_NUM)) > (64'(LOOK_LIM) << AFB);
        if (n_vert) begin
            n_t[0] = '0;
            n_t[1] = VW'($signed(w_f[2]));
            n_t[2] = -VW'($signed(w_f[1]));
        end else begin
            n_t[0] = -VW'($signed(w_f[1]));
            n_t[1] = VW'($signed(w_f[0]));
            n_t[2] = '0;
        end
        n_u[0] = VW'(r_x1_p[0] - r_x1_p[1]);
        n_u[1] = VW'(r_x1_p[2] - r_x1_p[3]);
        n_u[2] = VW'(r_x1_p[4] - r_x1_p[5]);
    end

    lab_norm u_norm_fwd (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_a_d),
        .o_axis (w_f)
    );

    lab_norm u_norm_side (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_t),
        .o_axis (w_s)
    );

    lab_norm u_norm_up (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_u),
        .o_axis (w_u)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NL; i++) begin
                r1_v[i] <= 1'b0;
                r2_v[i] <= 1'b0;
                r3_v[i] <= 1'b0;
            end
            r_x1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r1_v[0] <= i_s_axis_tvalid;
            r2_v[0] <= r1_v[NL];
            r_x1_v  <= r2_v[NL];
            r3_v[0] <= r_x1_v;
            for (int i = 1; i <= NL; i++) begin
                r1_v[i] <= r1_v[i-1];
                r2_v[i] <= r2_v[i-1];
                r3_v[i] <= r3_v[i-1];
            end
            r_out_v <= r3_v[NL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d     <= n_d;
            r1_c[0]   <= n_c0;
            r_b_lo    <= n_lo;
            r_b_small <= n_small;
            for (int c = 0; c < 3; c++) begin
                r_c_sq[c] <= (2*CF)'(r_b_lo[c]) * (2*CF)'(r_b_lo[c]);
            end
            r_c_small <= r_b_small;
            for (int i = 1; i <= NL; i++) begin
                if (i == 3) begin
                    r1_c[i] <= n_c3;
                end else begin
                    r1_c[i] <= r1_c[i-1];
                end
                r2_c[i] <= r2_c[i-1];
                r3_c[i] <= r3_c[i-1];
            end

            r_t       <= n_t;
            r2_c[0]   <= n_c2;

            r_x1_c   <= n_x1;
            r_x1_p[0] <= $signed(r2_c[NL].f[1]) * $signed(w_s[2]);
            r_x1_p[1] <= $signed(r2_c[NL].f[2]) * $signed(w_s[1]);
            r_x1_p[2] <= $signed(r2_c[NL].f[2]) * $signed(w_s[0]);
            r_x1_p[3] <= $signed(r2_c[NL].f[0]) * $signed(w_s[2]);
            r_x1_p[4] <= $signed(r2_c[NL].f[0]) * $signed(w_s[1]);
            r_x1_p[5] <= $signed(r2_c[NL].f[1]) * $signed(w_s[0]);

            r_u     <= n_u;
            r3_c[0] <= r_x1_c;

            r_out_pos <= r3_c[NL].obj;
            if (r3_c[NL].near) begin
                r_out_fwd  <= {AW'(0), AW'(0), AXIS_ONE};
                r_out_side <= {AW'(0), AXIS_ONE, AW'(0)};
                r_out_up   <= {AXIS_ONE, AW'(0), AW'(0)};
            end else begin
                r_out_fwd  <= r3_c[NL].f;
                r_out_side <= r3_c[NL].s;
                r_out_up   <= w_u;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_pos, r_out_up, r_out_side, r_out_fwd};

endmodule
